// ----- src/wlc_pkg.sv -----
// Package for the weighted LRU cache manager: field widths, codes, word types,
// memory entry layout and state machine type. No dependencies.
`default_nettype none

package wlc_pkg;

   localparam int KEY_W  = 32;
   localparam int OWN_W  = 4;
   localparam int WGT_W  = 16;
   localparam int PIN_W  = 8;
   localparam int SLOT_W = 5;
   localparam int TOT_W  = 22;
   localparam int FUNC_W = 2;
   localparam int KIND_W = 2;
   localparam int STAT_W = 2;
   localparam int CNT_W  = 6;

   localparam logic [TOT_W-1:0] TOTAL_MAX    = '1;
   localparam logic [TOT_W-1:0] BUDGET_RESET = 22'd200000;
   localparam logic [CNT_W-1:0] MAX_EVICT    = 6'd31;
   localparam logic [PIN_W-1:0] PIN_MAX      = '1;

   localparam logic [FUNC_W-1:0] FUNC_LOOKUP  = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_PIN_INC = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_PIN_DEC = 2'd2;

   localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd0;
   localparam logic [KIND_W-1:0] KIND_EVICT  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_PIN    = 2'd2;

   localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
   localparam logic [STAT_W-1:0] STAT_FULL    = 2'd1;
   localparam logic [STAT_W-1:0] STAT_IGNORED = 2'd2;

   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic [OWN_W-1:0]  cache_sel;
      logic [KEY_W-1:0]  lookup_key;
      logic [WGT_W-1:0]  miss_weight;
      logic [SLOT_W-1:0] target_slot;
   } req_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [SLOT_W-1:0] slot;
      logic              hit;
      logic [STAT_W-1:0] status;
      logic [TOT_W-1:0]  total_weight;
      logic              last;
   } rsp_type;

   typedef struct packed {
      logic [KEY_W-1:0] key;
      logic [OWN_W-1:0] owner;
      logic [WGT_W-1:0] weight;
      logic [PIN_W-1:0] pin;
   } mem_entry_type;

   typedef enum logic [1:0] {
      REC_NONE,
      REC_HIT,
      REC_DROP,
      REC_ALLOC
   } rec_op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PIN_RD,
      ST_PIN_WR,
      ST_SCAN,
      ST_MISS,
      ST_FWALK_RD,
      ST_FWALK_CHK,
      ST_ALLOC,
      ST_EWALK_RD,
      ST_EWALK_CHK,
      ST_FIN
   } state_type;

endpackage

`default_nettype wire

// ----- src/weighted_lru_cache_manager_core.sv -----
// Top level of the weighted LRU cache manager: command port, control sequencer,
// result register. Depends on wlc_pkg, wlc_entry_mem and wlc_recency.
`default_nettype none

// An item is taken when start is high and busy is low; each result word appears
// on rsp_data for exactly one cycle with rsp_valid high and must be captured
// then, as the block cannot be held off. Steps per item: a pin increment or
// decrement reads the target slot and then writes it back; a lookup scans the
// entry memory one slot a cycle through its single read port and answers a hit
// from the scan; a miss then takes a free slot or walks the recency positions
// for a forced eviction (each step reads one slot), allocates and, once the
// budget is reached, walks again for budget evictions before a closing state
// gives the final answer. A lookup with an out-of-range sub-cache is answered
// straight from idle; an unused function code produces no word. The weight
// budget register is written over the csr channel, which is ready while idle.
module weighted_lru_cache_manager_core #(
   parameter int ENTRIES = 32,
   parameter int CACHES  = 16
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire wlc_pkg::req_type req_word,
   output logic                  rsp_valid,
   output wlc_pkg::rsp_type      rsp_data,
   input  wire logic             csr_valid,
   output logic                  csr_ready,
   input  wire logic [wlc_pkg::TOT_W-1:0] csr_wdata
);
   import wlc_pkg::*;

   localparam int IW = $clog2(ENTRIES);
   localparam logic [OWN_W:0]    CACHES_LIM  = (OWN_W + 1)'(CACHES);
   localparam logic [SLOT_W+1:0] ENTRIES_LIM = (SLOT_W + 2)'(ENTRIES);
   localparam logic [IW:0]       SCAN_END    = (IW + 1)'(ENTRIES);
   localparam logic [IW-1:0]     LAST_RANK   = IW'(ENTRIES - 1);

   state_type         state_ff, state_in;
   req_type           op_ff, op_in;
   logic [IW:0]       scan_ff, scan_in;
   logic              chk_vld_ff, chk_vld_in;
   logic [IW-1:0]     chk_idx_ff, chk_idx_in;
   logic [IW-1:0]     pos_ff, pos_in;
   logic [IW-1:0]     slot_ff, slot_in;
   logic [IW-1:0]     cand_ff, cand_in;
   logic              cand_vld_ff, cand_vld_in;
   logic [CNT_W-1:0]  n_ff, n_in;
   logic [IW:0]       live_ff, live_in;
   logic [TOT_W-1:0]  total_ff, total_in;
   logic [TOT_W-1:0]  budget_ff, budget_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   // store interfaces
   rec_op_type        rec_op;
   logic [IW-1:0]     rec_idx;
   logic [IW-1:0]     query_rank;
   logic [ENTRIES-1:0] valid_vec;
   logic              free_found, rank_found;
   logic [IW-1:0]     free_idx, rank_idx;
   logic              wr_en;
   logic [IW-1:0]     wr_addr, rd_addr;
   mem_entry_type     wr_data, rd_data;

   // datapath helpers
   logic [TOT_W-1:0]  wgt_ext, total_drop, total_add;
   logic [TOT_W:0]    sum_wide;
   logic              sel_ok, req_sel_ok, tgt_ok, pin_ok, key_hit, evict;
   logic [IW-1:0]     tgt_idx;
   logic [TOT_W-1:0]  tot_after;
   logic [CNT_W-1:0]  n_after;

   function automatic rsp_type mk_rsp(input logic [KIND_W-1:0] kind,
                                      input logic [SLOT_W-1:0] slot,
                                      input logic              hit,
                                      input logic [STAT_W-1:0] status,
                                      input logic [TOT_W-1:0]  total,
                                      input logic              last);
      rsp_type r;
      r.kind         = kind;
      r.slot         = slot;
      r.hit          = hit;
      r.status       = status;
      r.total_weight = total;
      r.last         = last;
      return r;
   endfunction

   wlc_entry_mem #(.DEPTH(ENTRIES)) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   wlc_recency #(.ENTRIES(ENTRIES)) u_rec (
      .clock      (clock),
      .reset      (reset),
      .op         (rec_op),
      .op_idx     (rec_idx),
      .query_rank (query_rank),
      .valid_vec  (valid_vec),
      .free_found (free_found),
      .free_idx   (free_idx),
      .rank_found (rank_found),
      .rank_idx   (rank_idx)
   );

   // weight arithmetic: floor at zero on removal, saturate on charge
   assign wgt_ext    = TOT_W'(rd_data.weight);
   assign total_drop = (total_ff >= wgt_ext) ? (total_ff - wgt_ext) : '0;
   assign sum_wide   = {1'b0, total_ff} + (TOT_W + 1)'(op_ff.miss_weight);
   assign total_add  = sum_wide[TOT_W] ? TOTAL_MAX : sum_wide[TOT_W-1:0];

   assign sel_ok     = {1'b0, op_ff.cache_sel} < CACHES_LIM;
   assign req_sel_ok = {1'b0, req_word.cache_sel} < CACHES_LIM;
   assign tgt_ok     = {2'b00, op_ff.target_slot} < ENTRIES_LIM;
   assign tgt_idx    = IW'(op_ff.target_slot);
   assign pin_ok     = tgt_ok && sel_ok && valid_vec[tgt_idx] &&
                       rd_data.owner == op_ff.cache_sel;
   assign key_hit    = chk_vld_ff && valid_vec[chk_idx_ff] &&
                       rd_data.owner == op_ff.cache_sel && rd_data.key == op_ff.lookup_key;
   assign evict      = cand_vld_ff && cand_ff != slot_ff && rd_data.pin == '0;
   assign tot_after  = evict ? total_drop : total_ff;
   assign n_after    = n_ff + CNT_W'(evict);

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      scan_in      = scan_ff;
      chk_vld_in   = 1'b0;
      chk_idx_in   = chk_idx_ff;
      pos_in       = pos_ff;
      slot_in      = slot_ff;
      cand_in      = cand_ff;
      cand_vld_in  = cand_vld_ff;
      n_in         = n_ff;
      live_in      = live_ff;
      total_in     = total_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      rec_op       = REC_NONE;
      rec_idx      = slot_ff;
      query_rank   = pos_ff;
      rd_addr      = '0;
      wr_en        = 1'b0;
      wr_addr      = slot_ff;
      wr_data      = rd_data;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               op_in = req_word;
               priority case (req_word.func)
                  FUNC_LOOKUP: begin
                     if (!req_sel_ok) begin
                        rsp_valid_in = 1'b1;
                        rsp_in = mk_rsp(KIND_LOOKUP, '0, 1'b0, STAT_IGNORED, total_ff, 1'b1);
                     end else begin
                        scan_in  = '0;
                        n_in     = '0;
                        state_in = ST_SCAN;
                     end
                  end
                  FUNC_PIN_INC, FUNC_PIN_DEC: begin
                     state_in = ST_PIN_RD;
                  end
                  default: begin
                     // unused code: drop the word silently
                  end
               endcase
            end
         end

         ST_PIN_RD: begin
            rd_addr  = tgt_idx;
            state_in = ST_PIN_WR;
         end

         ST_PIN_WR: begin
            wr_addr = tgt_idx;
            if (pin_ok) begin
               wr_en = 1'b1;
               if (op_ff.func == FUNC_PIN_INC && rd_data.pin != PIN_MAX) begin
                  wr_data.pin = rd_data.pin + PIN_W'(1);
               end else if (op_ff.func == FUNC_PIN_DEC && rd_data.pin != '0) begin
                  wr_data.pin = rd_data.pin - PIN_W'(1);
               end
            end
            rsp_valid_in = 1'b1;
            rsp_in = mk_rsp(KIND_PIN, op_ff.target_slot, 1'b0,
                            pin_ok ? STAT_OK : STAT_IGNORED, total_ff, 1'b1);
            state_in = ST_IDLE;
         end

         ST_SCAN: begin
            // issue one read a cycle, compare the word read the cycle before
            rd_addr = scan_ff[IW-1:0];
            if (key_hit) begin
               rec_op       = REC_HIT;
               rec_idx      = chk_idx_ff;
               rsp_valid_in = 1'b1;
               rsp_in = mk_rsp(KIND_LOOKUP, SLOT_W'(chk_idx_ff), 1'b1, STAT_OK,
                               total_ff, 1'b1);
               state_in = ST_IDLE;
            end else if (scan_ff != SCAN_END) begin
               scan_in    = scan_ff + (IW + 1)'(1);
               chk_vld_in = 1'b1;
               chk_idx_in = scan_ff[IW-1:0];
            end else if (!chk_vld_ff) begin
               state_in = ST_MISS;
            end
         end

         ST_MISS: begin
            if (free_found) begin
               slot_in  = free_idx;
               state_in = ST_ALLOC;
            end else begin
               pos_in   = LAST_RANK;
               state_in = ST_FWALK_RD;
            end
         end

         ST_FWALK_RD: begin
            rd_addr     = rank_idx;
            cand_in     = rank_idx;
            cand_vld_in = rank_found;
            state_in    = ST_FWALK_CHK;
         end

         ST_FWALK_CHK: begin
            if (cand_vld_ff && rd_data.pin == '0) begin
               rec_op       = REC_DROP;
               rec_idx      = cand_ff;
               total_in     = total_drop;
               live_in      = live_ff - (IW + 1)'(1);
               n_in         = CNT_W'(1);
               slot_in      = cand_ff;
               rsp_valid_in = 1'b1;
               rsp_in = mk_rsp(KIND_EVICT, SLOT_W'(cand_ff), 1'b0, STAT_OK,
                               total_drop, 1'b0);
               state_in = ST_ALLOC;
            end else if (pos_ff == '0) begin
               rsp_valid_in = 1'b1;
               rsp_in = mk_rsp(KIND_LOOKUP, '0, 1'b0, STAT_FULL, total_ff, 1'b1);
               state_in = ST_IDLE;
            end else begin
               pos_in   = pos_ff - IW'(1);
               state_in = ST_FWALK_RD;
            end
         end

         ST_ALLOC: begin
            rec_op         = REC_ALLOC;
            rec_idx        = slot_ff;
            wr_en          = 1'b1;
            wr_data.key    = op_ff.lookup_key;
            wr_data.owner  = op_ff.cache_sel;
            wr_data.weight = op_ff.miss_weight;
            wr_data.pin    = '0;
            total_in       = total_add;
            live_in        = live_ff + (IW + 1)'(1);
            if (total_add >= budget_ff) begin
               // walk starts at the least-recent rank after allocation
               pos_in   = IW'(live_ff);
               state_in = ST_EWALK_RD;
            end else begin
               rsp_valid_in = 1'b1;
               rsp_in = mk_rsp(KIND_LOOKUP, SLOT_W'(slot_ff), 1'b0, STAT_OK,
                               total_add, 1'b1);
               state_in = ST_IDLE;
            end
         end

         ST_EWALK_RD: begin
            rd_addr     = rank_idx;
            cand_in     = rank_idx;
            cand_vld_in = rank_found;
            state_in    = ST_EWALK_CHK;
         end

         ST_EWALK_CHK: begin
            if (evict) begin
               rec_op       = REC_DROP;
               rec_idx      = cand_ff;
               total_in     = total_drop;
               live_in      = live_ff - (IW + 1)'(1);
               rsp_valid_in = 1'b1;
               rsp_in = mk_rsp(KIND_EVICT, SLOT_W'(cand_ff), 1'b0, STAT_OK,
                               total_drop, 1'b0);
            end
            n_in = n_after;
            if (tot_after <= budget_ff || pos_ff == '0 || n_after >= MAX_EVICT) begin
               state_in = ST_FIN;
            end else begin
               pos_in   = pos_ff - IW'(1);
               state_in = ST_EWALK_RD;
            end
         end

         ST_FIN: begin
            rsp_valid_in = 1'b1;
            rsp_in = mk_rsp(KIND_LOOKUP, SLOT_W'(slot_ff), 1'b0, STAT_OK, total_ff, 1'b1);
            state_in = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign csr_ready = (state_ff == ST_IDLE);
   assign budget_in = (csr_valid && csr_ready) ? csr_wdata : budget_ff;

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         chk_vld_ff   <= 1'b0;
         cand_vld_ff  <= 1'b0;
         n_ff         <= '0;
         live_ff      <= '0;
         total_ff     <= '0;
         budget_ff    <= BUDGET_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         chk_vld_ff   <= chk_vld_in;
         cand_vld_ff  <= cand_vld_in;
         n_ff         <= n_in;
         live_ff      <= live_in;
         total_ff     <= total_in;
         budget_ff    <= budget_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload: no reset needed
   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      scan_ff    <= scan_in;
      chk_idx_ff <= chk_idx_in;
      pos_ff     <= pos_in;
      slot_ff    <= slot_in;
      cand_ff    <= cand_in;
      rsp_ff     <= rsp_in;
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // live counter must track the valid bits
   a_live_count : assert property (@(posedge clock) disable iff (reset)
      live_ff == (IW + 1)'($countones(valid_vec)))
      else $error("live count out of step with valid bits");

   // the final word of an item is shown only once the sequencer is back at rest
   a_last_idle : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.last |-> !busy)
      else $error("final word shown while still busy");

   // an eviction notice is always followed by more words of the same item
   a_evict_mid : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.kind == KIND_EVICT |-> busy && !rsp_data.last)
      else $error("eviction notice outside an item");

endmodule

`default_nettype wire

// ----- src/wlc_entry_mem.sv -----
// Entry store: key, owner, weight and pin count per slot.
// One write port, one read port with registered data. Uses wlc_pkg.
`default_nettype none

module wlc_entry_mem #(
   parameter int DEPTH = 32,
   localparam int AW = $clog2(DEPTH)
) (
   input  wire logic                   clock,
   input  wire logic                   wr_en,
   input  wire logic [AW-1:0]          wr_addr,
   input  wire wlc_pkg::mem_entry_type wr_data,
   input  wire logic [AW-1:0]          rd_addr,
   output wlc_pkg::mem_entry_type      rd_data
);
   import wlc_pkg::*;

   mem_entry_type mem [DEPTH];
   mem_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- src/wlc_recency.sv -----
// Valid bits and recency ranks of all slots, with free-slot and rank lookups.
// Applies one hit, drop or allocate update a cycle. Uses wlc_pkg.
`default_nettype none

module wlc_recency #(
   parameter int ENTRIES = 32,
   localparam int IW = $clog2(ENTRIES)
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire wlc_pkg::rec_op_type op,
   input  wire logic [IW-1:0]       op_idx,
   input  wire logic [IW-1:0]       query_rank,
   output logic [ENTRIES-1:0]       valid_vec,
   output logic                     free_found,
   output logic [IW-1:0]            free_idx,
   output logic                     rank_found,
   output logic [IW-1:0]            rank_idx
);
   import wlc_pkg::*;

   logic [ENTRIES-1:0] valid_ff, valid_in;
   logic [IW-1:0]      rank_ff [ENTRIES];
   logic [IW-1:0]      rank_in [ENTRIES];
   logic [IW-1:0]      sel_rank;

   always_comb begin
      valid_in = valid_ff;
      rank_in  = rank_ff;
      sel_rank = rank_ff[op_idx];
      unique case (op)
         REC_HIT: begin
            for (int j = 0; j < ENTRIES; j++) begin
               if (IW'(j) != op_idx && valid_ff[j] && rank_ff[j] < sel_rank) begin
                  rank_in[j] = rank_ff[j] + IW'(1);
               end
            end
            rank_in[op_idx] = '0;
         end
         REC_DROP: begin
            for (int j = 0; j < ENTRIES; j++) begin
               if (valid_ff[j] && rank_ff[j] > sel_rank) begin
                  rank_in[j] = rank_ff[j] - IW'(1);
               end
            end
            valid_in[op_idx] = 1'b0;
         end
         REC_ALLOC: begin
            for (int j = 0; j < ENTRIES; j++) begin
               if (valid_ff[j]) begin
                  rank_in[j] = rank_ff[j] + IW'(1);
               end
            end
            valid_in[op_idx] = 1'b1;
            rank_in[op_idx]  = '0;
         end
         REC_NONE: begin
         end
      endcase
   end

   // lowest free slot wins
   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int j = ENTRIES - 1; j >= 0; j--) begin
         if (!valid_ff[j]) begin
            free_found = 1'b1;
            free_idx   = IW'(j);
         end
      end
   end

   always_comb begin
      rank_found = 1'b0;
      rank_idx   = '0;
      for (int j = 0; j < ENTRIES; j++) begin
         if (valid_ff[j] && rank_ff[j] == query_rank) begin
            rank_found = 1'b1;
            rank_idx   = IW'(j);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rank_ff <= rank_in;
   end

   assign valid_vec = valid_ff;

endmodule

`default_nettype wire

// ----- test/tb.sv -----
// Self-checking testbench for weighted_lru_cache_manager_core: directed and random
// lookups and pin operations checked by a scoreboard. Depends on wlc_pkg and the core.
`timescale 1ns / 100ps

module tb;
   import wlc_pkg::*;

   localparam int NSLOT = 32;
   localparam int EVICT_CAP = 31;
   localparam int WEIGHT_SAT = 4194303;
   localparam int DRAIN_CYCLES = 150;
   localparam int CYCLE_LIMIT = 1000000;
   localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

   // Scoreboard: mirror of the entry store, and the queue of result words it predicts.
   class cache_scoreboard;
      bit vld[NSLOT];
      logic [KEY_W-1:0] key[NSLOT];
      logic [OWN_W-1:0] own[NSLOT];
      int unsigned wgt[NSLOT];
      int unsigned pin[NSLOT];
      int rank[NSLOT];
      int unsigned total;
      int unsigned budget;
      rsp_type pending[$];
      int errors;
      int words;
      int evictions;

      function new();
         budget = BUDGET_RESET;
      endfunction

      function void push(logic [KIND_W-1:0] k, int s, bit h, logic [STAT_W-1:0] st, bit l);
         rsp_type r;
         r.kind = k;
         r.slot = s[SLOT_W-1:0];
         r.hit = h;
         r.status = st;
         r.total_weight = total[TOT_W-1:0];
         r.last = l;
         pending.push_back(r);
      endfunction

      function int live();
         int n;
         n = 0;
         foreach (vld[i]) if (vld[i]) n++;
         return n;
      endfunction

      function int at_rank(int p);
         foreach (vld[i]) if (vld[i] && rank[i] == p) return i;
         return -1;
      endfunction

      function void drop(int s);
         vld[s] = 0;
         foreach (vld[i]) if (vld[i] && rank[i] > rank[s]) rank[i]--;
         total = (total >= wgt[s]) ? total - wgt[s] : 0;
         evictions++;
      endfunction

      // Work out the result words one accepted command word causes.
      function void note_item(req_type r);
         int t, s, n, i, p;
         bit ok;
         t = r.target_slot;
         n = 0;
         s = -1;
         if (r.func == FUNC_UNUSED) return;
         if (r.func != FUNC_LOOKUP) begin
            ok = vld[t] && own[t] == r.cache_sel;
            if (ok && r.func == FUNC_PIN_INC && pin[t] < 255) pin[t]++;
            else if (ok && r.func == FUNC_PIN_DEC && pin[t] > 0) pin[t]--;
            push(KIND_PIN, t, 0, ok ? STAT_OK : STAT_IGNORED, 1);
            return;
         end
         for (i = 0; i < NSLOT; i++) begin
            if (vld[i] && own[i] == r.cache_sel && key[i] == r.lookup_key) begin
               foreach (vld[j]) if (j != i && vld[j] && rank[j] < rank[i]) rank[j]++;
               rank[i] = 0;
               push(KIND_LOOKUP, i, 1, STAT_OK, 1);
               return;
            end
         end
         for (i = 0; i < NSLOT; i++) if (!vld[i]) begin
            s = i;
            break;
         end
         if (s < 0) begin
            for (p = live() - 1; p >= 0; p--) begin
               i = at_rank(p);
               if (i >= 0 && pin[i] == 0) begin
                  s = i;
                  break;
               end
            end
            if (s < 0) begin
               push(KIND_LOOKUP, 0, 0, STAT_FULL, 1);
               return;
            end
            drop(s);
            push(KIND_EVICT, s, 0, STAT_OK, 0);
            n++;
         end
         foreach (vld[j]) if (vld[j]) rank[j]++;
         vld[s] = 1;
         key[s] = r.lookup_key;
         own[s] = r.cache_sel;
         wgt[s] = r.miss_weight;
         pin[s] = 0;
         rank[s] = 0;
         total += r.miss_weight;
         if (total > WEIGHT_SAT) total = WEIGHT_SAT;
         if (total >= budget) begin
            for (p = live() - 1; p >= 0 && n < EVICT_CAP; p--) begin
               i = at_rank(p);
               if (i >= 0 && i != s && pin[i] == 0) begin
                  drop(i);
                  push(KIND_EVICT, i, 0, STAT_OK, 0);
                  n++;
               end
               if (!(total > budget)) break;
            end
         end
         push(KIND_LOOKUP, s, 0, STAT_OK, 1);
      endfunction

      function void check(rsp_type a);
         rsp_type e;
         words++;
         if (pending.size() == 0) begin
            $error("unexpected result word %p", a);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (a.kind !== e.kind) begin
            $error("kind: expected %0d, got %0d", e.kind, a.kind);
            errors++;
         end
         if (a.slot !== e.slot) begin
            $error("slot: expected %0d, got %0d", e.slot, a.slot);
            errors++;
         end
         if (a.hit !== e.hit) begin
            $error("hit: expected %0d, got %0d", e.hit, a.hit);
            errors++;
         end
         if (a.status !== e.status) begin
            $error("status: expected %0d, got %0d", e.status, a.status);
            errors++;
         end
         if (a.total_weight !== e.total_weight) begin
            $error("total_weight: expected %0d, got %0d", e.total_weight, a.total_weight);
            errors++;
         end
         if (a.last !== e.last) begin
            $error("last: expected %0d, got %0d", e.last, a.last);
            errors++;
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic start = 0;
   logic busy;
   req_type req_word = '0;
   logic rsp_valid;
   rsp_type rsp_data;
   logic csr_valid = 0;
   logic csr_ready;
   logic [TOT_W-1:0] csr_wdata = '0;

   cache_scoreboard sb = new();
   int cycles = 0;
   int items = 0;
   bit gaps_on = 1;
   logic [KEY_W-1:0] key_pool[24];

   weighted_lru_cache_manager_core u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_word(req_word),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data), .csr_valid(csr_valid),
      .csr_ready(csr_ready), .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   // Check each result word at the edge that ends its cycle.
   always @(posedge clock) begin
      if (!reset && rsp_valid) sb.check(rsp_data);
   end

   // Watchdog: abandon the run if the block stops answering.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("weighted_lru_cache_manager_core test failed");
         $finish;
      end
   end

   // Offer one command word and hold it until taken; leave start high for the next one.
   task automatic send(logic [FUNC_W-1:0] f, int sel, logic [KEY_W-1:0] k, int w, int t);
      req_type r;
      r.func = f;
      r.cache_sel = sel[OWN_W-1:0];
      r.lookup_key = k;
      r.miss_weight = w[WGT_W-1:0];
      r.target_slot = t[SLOT_W-1:0];
      start <= 1;
      req_word <= r;
      do @(posedge clock); while (busy);
      sb.note_item(r);
      items++;
      // Drop start for a random burst now and then.
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         start <= 0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   endtask

   // Let every expected word arrive, then allow for any trailing work.
   task automatic drain();
      start <= 0;
      @(posedge clock);
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_budget(int unsigned v);
      drain();
      csr_valid <= 1;
      csr_wdata <= v[TOT_W-1:0];
      do @(posedge clock); while (!csr_ready);
      sb.budget = v;
      csr_valid <= 0;
   endtask

   task automatic lookup(int sel, logic [KEY_W-1:0] k, int w);
      send(FUNC_LOOKUP, sel, k, w, 0);
   endtask

   // Pin command on a slot, mostly from its owner so that it takes effect.
   task automatic pin_op(logic [FUNC_W-1:0] f, int t, bit own);
      send(f, own ? int'(sb.own[t]) : $urandom_range(0, 15), $urandom, $urandom_range(0, 65535), t);
   endtask

   // Random traffic: keys drawn mostly from a small pool so hits recur.
   task automatic random_phase(int n);
      int c;
      logic [KEY_W-1:0] k;
      repeat (n) begin
         c = $urandom_range(0, 99);
         k = ($urandom_range(0, 3) == 0) ? $urandom : key_pool[$urandom_range(0, 23)];
         if (c < 60) lookup($urandom_range(0, 3) == 0 ? $urandom_range(0, 15) : $urandom_range(0, 2),
                            k, $urandom_range(0, 65535));
         else if (c < 72) pin_op(FUNC_PIN_INC, $urandom_range(0, 31), $urandom_range(0, 4) != 0);
         else if (c < 94) pin_op(FUNC_PIN_DEC, $urandom_range(0, 31), $urandom_range(0, 4) != 0);
         else send(FUNC_UNUSED, $urandom_range(0, 15), $urandom, $urandom_range(0, 65535),
                   $urandom_range(0, 31));
      end
   endtask

   initial begin
      foreach (key_pool[i]) key_pool[i] = $urandom;
      repeat (8) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Basic cases at the reset budget: unused code, miss then hit, field extremes.
      send(FUNC_UNUSED, 0, 0, 0, 0);
      lookup(0, 32'h0, 0);
      lookup(0, 32'h0, 0);
      lookup(15, 32'hFFFF_FFFF, 65535);
      pin_op(FUNC_PIN_INC, 0, 1);
      send(FUNC_PIN_INC, 1, 0, 0, 0);        // foreign owner, ignored
      send(FUNC_PIN_DEC, 3, 0, 0, 31);       // invalid slot, ignored
      pin_op(FUNC_PIN_DEC, 0, 1);
      pin_op(FUNC_PIN_DEC, 0, 1);            // floor at zero
      repeat (4) lookup(2, $urandom, 65535); // cross the budget

      // Fill the store under the largest budget, pin it all, then miss on a full store.
      write_budget(WEIGHT_SAT);
      for (int i = 0; i < NSLOT; i++) lookup(i % 16, 32'h1000 + i, $urandom_range(0, 65535));
      for (int i = 0; i < NSLOT; i++) pin_op(FUNC_PIN_INC, i, 1);
      lookup(5, 32'hDEAD_0000, 7);
      for (int i = 0; i < NSLOT; i++) pin_op(FUNC_PIN_DEC, i, 1);

      // Minimum budget on a full store: forced eviction plus the walk up to its cap.
      write_budget(1);
      lookup(9, 32'hBEEF_0001, 65535);
      // Budget hit exactly.
      write_budget(1000);
      lookup(4, 32'hBEEF_0002, 1000);

      random_phase(70);
      write_budget(200000);
      random_phase(60);
      write_budget(1);
      random_phase(40);
      write_budget(WEIGHT_SAT);
      random_phase(70);
      drain();                                // hold until every word has come
      write_budget(500000);
      random_phase(50);
      gaps_on = 0;
      random_phase(50);

      drain();
      $display("covered %0d command words, %0d result words, %0d evictions, budgets 1 to max",
               items, sb.words, sb.evictions);
      if (sb.errors == 0 && sb.pending.size() == 0)
         $display("weighted_lru_cache_manager_core test passed");
      else
         $display("weighted_lru_cache_manager_core test failed");
      $finish;
   end
endmodule
